// ===== hdl/fpfa_pkg.sv =====
// shared types, codes and widths for the fixed partition fit allocator
package fpfa_pkg;

  localparam int CMD_W    = 1;
  localparam int INDEX_W  = 4;
  localparam int SIZE_W   = 16;
  localparam int OWNER_W  = 16;
  localparam int STRAT_W  = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;

  localparam int DEF_MAX_PARTITIONS = 16;
  localparam int DEF_SIZE_BITS      = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

  localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_NEXT  = 2'd2;
  localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_LOADED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PLACED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOFIT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  chosen_index;
  } result_t;

endpackage

// ===== hdl/fpfa_in_if.sv =====
// request channel: load and allocate items
interface fpfa_in_if;
  import fpfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [INDEX_W-1:0] partition_index;
  logic [SIZE_W-1:0]  partition_size;
  logic [SIZE_W-1:0]  request_size;
  logic [OWNER_W-1:0] owner_id;
  logic [STRAT_W-1:0] strategy;

  modport source (
    output valid, cmd, partition_index, partition_size, request_size, owner_id, strategy,
    input  ready
  );

  modport sink (
    input  valid, cmd, partition_index, partition_size, request_size, owner_id, strategy,
    output ready
  );
endinterface

// ===== hdl/fpfa_out_if.sv =====
// response channel: status and chosen partition
interface fpfa_out_if;
  import fpfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  chosen_index;

  modport source (
    output valid, status, chosen_index,
    input  ready
  );

  modport sink (
    input  valid, status, chosen_index,
    output ready
  );
endinterface

// ===== hdl/fpfa_table.sv =====
// partition table memory: size and owner per entry, one read and one write port
module fpfa_table #(
  parameter int MAX_PARTITIONS = fpfa_pkg::DEF_MAX_PARTITIONS,
  parameter int SIZE_BITS      = fpfa_pkg::DEF_SIZE_BITS
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [$clog2(MAX_PARTITIONS)-1:0]   rd_addr,
  output logic [SIZE_BITS-1:0]                rd_size,
  output logic [fpfa_pkg::OWNER_W-1:0]        rd_owner,
  input  logic                                wr_en,
  input  logic [$clog2(MAX_PARTITIONS)-1:0]   wr_addr,
  input  logic [SIZE_BITS-1:0]                wr_size,
  input  logic [fpfa_pkg::OWNER_W-1:0]        wr_owner
);
  import fpfa_pkg::*;

  localparam int WORD_W = OWNER_W + SIZE_BITS;

  logic [WORD_W-1:0] mem [MAX_PARTITIONS];
  logic [WORD_W-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_owner, wr_size};
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_size  = rd_word[SIZE_BITS-1:0];
  assign rd_owner = rd_word[WORD_W-1:SIZE_BITS];

endmodule

// ===== hdl/fpfa_ctrl.sv =====
// sequencer: load read-modify-write, partition scan, taken bits and rover
module fpfa_ctrl #(
  parameter int MAX_PARTITIONS = fpfa_pkg::DEF_MAX_PARTITIONS,
  parameter int SIZE_BITS      = fpfa_pkg::DEF_SIZE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  fpfa_in_if.sink                               req,
  input  logic [$clog2(MAX_PARTITIONS+1)-1:0]   count,
  output fpfa_pkg::result_t                     res,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output logic                                  rd_en,
  output logic [$clog2(MAX_PARTITIONS)-1:0]     rd_addr,
  input  logic [SIZE_BITS-1:0]                  rd_size,
  input  logic [fpfa_pkg::OWNER_W-1:0]          rd_owner,
  output logic                                  wr_en,
  output logic [$clog2(MAX_PARTITIONS)-1:0]     wr_addr,
  output logic [SIZE_BITS-1:0]                  wr_size,
  output logic [fpfa_pkg::OWNER_W-1:0]          wr_owner
);
  import fpfa_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTITIONS);
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

  state_t state, state_next;

  // latched item
  logic [SIZE_BITS-1:0] need;
  logic [SIZE_BITS-1:0] load_size;
  logic [OWNER_W-1:0]   owner;
  logic [STRAT_W-1:0]   strat;
  logic [IDX_W-1:0]     load_addr;
  logic                 load_ok;

  // scan
  logic [IDX_W-1:0] scan_idx;
  logic [CNT_W-1:0] issue_left;
  logic             cmp_valid;
  logic             cmp_last;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  logic [IDX_W-1:0] pick;
  logic [SIZE_BITS-1:0] pick_size;

  logic [MAX_PARTITIONS-1:0] taken;
  logic [IDX_W-1:0]          rover;

  logic             accept;
  logic             issue;
  logic             fit;
  logic             better;
  logic             commit;
  logic [IDX_W-1:0] start;
  logic [IDX_W-1:0] scan_idx_inc;
  logic [IDX_W-1:0] pick_inc;

  assign accept = req.valid && req.ready;
  assign issue  = (state == ST_SCAN) && (issue_left != '0);
  assign fit    = !taken[cmp_idx] && (rd_size >= need);

  always_comb begin
    better = 1'b0;
    case (strat)
      STRAT_BEST:  better = !found || (rd_size < pick_size);
      STRAT_WORST: better = !found || (rd_size > pick_size);
      default:     better = !found;
    endcase
  end

  // next fit starts at the rover only while it lies inside the searched range
  assign start = ((req.strategy == STRAT_NEXT) && (CNT_W'(rover) < count)) ? rover : '0;
  assign scan_idx_inc = ((CNT_W'(scan_idx) + 1'b1) == count) ? '0 : scan_idx + 1'b1;
  assign pick_inc     = ((CNT_W'(pick) + 1'b1) == count) ? '0 : pick + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    res_valid  = 1'b0;
    res        = '0;
    commit     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = scan_idx;
    wr_en      = 1'b0;
    wr_addr    = pick;
    wr_size    = pick_size;
    wr_owner   = owner;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.cmd == CMD_LOAD) begin
            rd_en      = 1'b1;
            rd_addr    = IDX_W'(req.partition_index);
            state_next = ST_LOAD_WR;
          end else if (count == '0) begin
            state_next = ST_COMMIT;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_LOAD_WR: begin
        res_valid  = 1'b1;
        res.status = STATUS_LOADED;
        if (res_ready) begin
          commit     = 1'b1;
          wr_en      = load_ok;
          wr_addr    = load_addr;
          wr_size    = load_size;
          wr_owner   = rd_owner;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        rd_en = issue;
        if (cmp_valid && cmp_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        res_valid        = 1'b1;
        res.status       = found ? STATUS_PLACED : STATUS_NOFIT;
        res.chosen_index = found ? INDEX_W'(pick) : '0;
        if (res_ready) begin
          commit     = 1'b1;
          wr_en      = found;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      found     <= 1'b0;
      taken     <= '0;
      rover     <= '0;
    end else begin
      if (accept) begin
        cmp_valid <= 1'b0;
        found     <= 1'b0;
      end else begin
        cmp_valid <= issue;
        if (cmp_valid && fit && better) begin
          found <= 1'b1;
        end
      end
      if (commit && (state == ST_LOAD_WR) && load_ok) begin
        taken[load_addr] <= 1'b0;
      end
      if (commit && (state == ST_COMMIT) && found) begin
        taken[pick] <= 1'b1;
        if (strat == STRAT_NEXT) begin
          rover <= pick_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      need       <= SIZE_BITS'(req.request_size);
      load_size  <= SIZE_BITS'(req.partition_size);
      owner      <= req.owner_id;
      strat      <= req.strategy;
      load_addr  <= IDX_W'(req.partition_index);
      load_ok    <= int'(req.partition_index) < MAX_PARTITIONS;
      scan_idx   <= start;
      issue_left <= count;
    end
    if (issue) begin
      cmp_idx    <= scan_idx;
      cmp_last   <= (issue_left == CNT_W'(1));
      scan_idx   <= scan_idx_inc;
      issue_left <= issue_left - 1'b1;
    end
    if (cmp_valid && fit && better) begin
      pick      <= cmp_idx;
      pick_size <= rd_size;
    end
  end

  a_write_on_result: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (res_valid && res_ready))
    else $error("table written outside a delivered result");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT && found) |-> (CNT_W'(pick) < count))
    else $error("chosen partition outside the searched range");

  a_place_marks_taken: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT && res_ready && found) |=> taken[$past(pick)])
    else $error("placed partition not marked taken");

  a_rover_moves_on_next_fit: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (rover != $past(rover))) |->
      $past(state == ST_COMMIT && res_ready && found && strat == STRAT_NEXT))
    else $error("rover moved outside a next fit placement");

endmodule

// ===== hdl/fixed_partition_fit_allocator.sv =====
// Fixed partition fit allocator: keeps a table of partitions and places allocate requests.
//
// Channels: req carries one item, either a load (cmd 0: write partition_size into
// partition_index and mark it free) or an allocate request (cmd 1: request_size, owner_id,
// strategy best/first/next/worst). rsp carries one item per request: status and
// chosen_index. cfg_wr_en/cfg_wr_data write partitions_in_use, the number of partitions
// searched; write it only while no request is in flight.
// Sequence: a load reads the entry's owner on acceptance and writes the entry back as its
// result is delivered. An allocate scans count entries, going straight to its result when
// count is zero, count being partitions_in_use clamped to MAX_PARTITIONS; the scan reads
// one table entry per cycle through the single read port of the table memory.
// A new item is accepted once the previous one has moved into the output register.
// Reset clears all taken marks, the next fit rover and sets partitions_in_use to 16;
// partition sizes are undefined until loaded, and no clearing pass is needed.
// When rsp stalls, one result waits in the output register and the sequencer holds
// its next result (and the table update that goes with it) until the register frees.
module fixed_partition_fit_allocator #(
  parameter int MAX_PARTITIONS = fpfa_pkg::DEF_MAX_PARTITIONS,
  parameter int SIZE_BITS      = fpfa_pkg::DEF_SIZE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  fpfa_in_if.sink                     req,
  fpfa_out_if.source                  rsp,
  input  logic                        cfg_wr_en,
  input  logic [fpfa_pkg::CFG_W-1:0]  cfg_wr_data
);
  import fpfa_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTITIONS);
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

  logic [CFG_W-1:0] partitions_in_use;
  logic [CNT_W-1:0] count;

  result_t res;
  logic    res_valid;
  logic    res_ready;

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [SIZE_BITS-1:0] rd_size;
  logic [OWNER_W-1:0]   rd_owner;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_size;
  logic [OWNER_W-1:0]   wr_owner;

  always_ff @(posedge clk) begin
    if (rst) begin
      partitions_in_use <= CFG_RESET;
    end else if (cfg_wr_en) begin
      partitions_in_use <= cfg_wr_data;
    end
  end

  // counts above the table depth search the whole table
  assign count = (int'(partitions_in_use) > MAX_PARTITIONS) ? CNT_W'(MAX_PARTITIONS)
                                                            : CNT_W'(partitions_in_use);

  fpfa_ctrl #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .count     (count),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_size   (rd_size),
    .rd_owner  (rd_owner),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_size   (wr_size),
    .wr_owner  (wr_owner)
  );

  fpfa_table #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_table (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_size  (rd_size),
    .rd_owner (rd_owner),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_size  (wr_size),
    .wr_owner (wr_owner)
  );

  // output register parts the sequencer from the receiver
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp.status       <= res.status;
      rsp.chosen_index <= res.chosen_index;
    end
  end

endmodule
